// ===== rtl/aocv_pkg.sv =====
package aocv_pkg;

  localparam int CELL_COUNT_DEF       = 4;
  localparam int SAMPLES_PER_CELL_DEF = 67;

  localparam logic [9:0]  DIFF_LIMIT  = 10'd480;
  localparam logic [31:0] DIFF_OFFSET = 32'd148945;
  localparam int          SCALE_SHIFT = 17;
  localparam logic [2:0]  TEMP_CHAN   = 3'd4;

  // Kinds of the next conversion
  localparam logic [1:0] KIND_DIFF   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_TEMP   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DIFF_GAINS   = 2'd0;
  localparam logic [1:0] REG_SINGLE_GAINS = 2'd1;
  localparam logic [1:0] REG_DIFF_CORR    = 2'd2;
  localparam logic [1:0] REG_TEMP_OFFSET  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_SCALE,
    ST_DONE,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/aocv_mul.sv =====
// Shift-add multiplier: two multiplicand bits per cycle.
// Product is a[AW-1:0] * b[BW-1:0], unsigned, exact.
module aocv_mul #(
  parameter int AW = 33,
  parameter int BW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            busy,
  output logic [AW+BW-1:0] prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(AW / 2 + 2);
  localparam logic [CW-1:0] STEPS = CW'((AW + 1) / 2);

  logic [AW-1:0] mcand;
  logic [PW-1:0] mplier;
  logic [CW-1:0] count;
  logic [PW-1:0] add0, add1;

  // Form the two partial products of this step
  always_comb begin
    add0 = mcand[0] ? mplier : '0;
    add1 = (AW > 1 && mcand[1]) ? (mplier << 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == STEPS - 1'b1) busy <= 1'b0;
    end
  end

  // Advance two bits a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= PW'(b);
      prod   <= '0;
    end else if (busy) begin
      prod   <= prod + add0 + add1;
      mcand  <= mcand >> 2;
      mplier <= mplier << 2;
    end
  end

endmodule

// ===== rtl/autorange_oversampling_cell_voltage_core.sv =====
// Cell voltage monitor: one 10-bit ADC conversion per input item, one result
// item per input item. A conversion that does not finish a cell channel loads
// the result register at its accepting edge, so its result is offered the next
// cycle. The next item waits until that result has been taken. The conversion
// that completes a cell channel runs the sum through a shared two-bit-per-cycle
// shift-add multiplier. Each multiply has a start, 17 shift-add steps and a
// hand-off. A differential channel needs the gain correction multiply first;
// a single-ended channel goes straight to the scaling multiply. One item is
// in work at a time; the next is accepted once the result register has been
// taken. Each result tells the next channel and conversion kind; the mux must
// follow it.
module autorange_oversampling_cell_voltage_core #(
  parameter int CELL_COUNT       = aocv_pkg::CELL_COUNT_DEF,
  parameter int SAMPLES_PER_CELL = aocv_pkg::SAMPLES_PER_CELL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] conversion
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] next_channel, [4:3] next_kind,
                                 // [5] result_valid, [8:6] result_index,
                                 // [24:9] measured_value
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int SW = 7;
  localparam logic [SW-1:0] SPC = SW'(SAMPLES_PER_CELL);
  localparam logic [2:0] LAST_CELL = 3'(CELL_COUNT - 1);

  // Configuration
  logic [63:0] diff_gains, single_gains;
  logic [15:0] diff_corr, temp_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_gains   <= '0;
      single_gains <= '0;
      diff_corr    <= 16'hFFFF;
      temp_offset  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aocv_pkg::REG_DIFF_GAINS:   diff_gains   <= cfg_data;
        aocv_pkg::REG_SINGLE_GAINS: single_gains <= cfg_data;
        aocv_pkg::REG_DIFF_CORR:    diff_corr    <= cfg_data[15:0];
        aocv_pkg::REG_TEMP_OFFSET:  temp_offset  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  aocv_pkg::state_t state, state_next;

  logic [2:0]    cur_ch;
  logic [SW-1:0] count;
  logic [31:0]   acc;
  logic          diff_flag;
  logic [15:0]   prev_v;
  logic          fin_diff;
  logic [2:0]    fin_ch;

  // Multiplier
  logic        mul_start, mul_busy;
  logic [32:0] mul_a;
  logic [15:0] mul_b;
  logic [48:0] mul_p;

  aocv_mul #(.AW(33), .BW(16)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .prod(mul_p)
  );

  logic        in_acc;
  logic [9:0]  code;
  logic [31:0] sample;
  logic        over;
  logic [15:0] gain;
  logic        acc_neg;
  logic [31:0] corr;
  logic [31:0] sum_off;
  logic [15:0] vtg;
  logic        out_load;
  logic [24:0] out_word;

  assign in_acc = s_tvalid && s_tready;
  assign code   = s_tdata[9:0];
  assign sample = diff_flag ? {{22{code[9]}}, code} : {22'd0, code};
  assign over   = diff_flag && (code[9] ? (code < 10'd544) : (code > aocv_pkg::DIFF_LIMIT));
  assign s_tready = (state == aocv_pkg::ST_IDLE) && !m_tvalid;

  // Select the channel gain
  always_comb begin
    gain = fin_diff ? diff_gains[16*fin_ch[1:0] +: 16] : single_gains[16*fin_ch[1:0] +: 16];
  end

  // Gain correction: multiply magnitude, restore sign, floor shift by 16
  always_comb begin
    corr = mul_p[47:16];
    if (acc_neg) corr = ~mul_p[47:16] + ((mul_p[15:0] == 16'd0) ? 32'd1 : 32'd0);
  end
  assign sum_off = acc + (fin_diff ? aocv_pkg::DIFF_OFFSET : 32'd0);
  logic [31:0] scaled;
  assign scaled = mul_p[31:0] + 32'd65536;
  assign vtg    = {1'b0, scaled[31:aocv_pkg::SCALE_SHIFT]};

  function automatic logic fin_diffn();
    fin_diffn = diff_flag && !(count == SW'(1) && over);
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      aocv_pkg::ST_IDLE:
        if (in_acc && cur_ch < aocv_pkg::TEMP_CHAN && count + 1'b1 >= SPC)
          state_next = fin_diffn() ? aocv_pkg::ST_CORR : aocv_pkg::ST_SCALE;
      aocv_pkg::ST_CORR:  if (!mul_busy && !mul_start) state_next = aocv_pkg::ST_SCALE;
      aocv_pkg::ST_SCALE: if (!mul_busy && !mul_start) state_next = aocv_pkg::ST_DONE;
      aocv_pkg::ST_DONE:  state_next = aocv_pkg::ST_IDLE;
      default:            state_next = aocv_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic phase_go;
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    unique case (state)
      aocv_pkg::ST_CORR: begin
        mul_start = phase_go;
        mul_a = {1'b0, acc_neg ? (~acc + 32'd1) : acc};
        mul_b = diff_corr;
      end
      aocv_pkg::ST_SCALE: begin
        mul_start = phase_go;
        mul_a = {1'b0, sum_off};
        mul_b = gain;
      end
      aocv_pkg::ST_DONE: out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) phase_go <= 1'b0;
    else phase_go <= (state_next != state) &&
                     (state_next == aocv_pkg::ST_CORR || state_next == aocv_pkg::ST_SCALE);
  end

  // Channel state and item bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aocv_pkg::ST_IDLE;
      cur_ch    <= '0;
      count     <= '0;
      acc       <= '0;
      diff_flag <= 1'b1;
      prev_v    <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (in_acc) begin
        if (cur_ch >= aocv_pkg::TEMP_CHAN) begin
          cur_ch   <= '0;
          out_word <= {{6'd0, code} - temp_offset, aocv_pkg::TEMP_CHAN, 1'b1,
                       aocv_pkg::KIND_DIFF, 3'd0};
          m_tvalid <= 1'b1;
        end else if (count + 1'b1 >= SPC) begin
          fin_diff <= fin_diffn();
          fin_ch   <= cur_ch;
          acc_neg  <= (count > SW'(2)) ? ((acc + sample) >> 31) != 0 : acc[31];
          if (count > SW'(2)) acc <= acc + sample;
        end else begin
          if (count > SW'(2)) acc <= acc + sample;
          if (count == SW'(1)) diff_flag <= !over;
          count    <= count + 1'b1;
          out_word <= {16'd0, 3'd0, 1'b0,
                       (count == SW'(1) ? !over : diff_flag) ? aocv_pkg::KIND_DIFF
                                                             : aocv_pkg::KIND_SINGLE,
                       cur_ch};
          m_tvalid <= 1'b1;
        end
      end
      if (state == aocv_pkg::ST_CORR && !mul_busy && !mul_start) acc <= corr;
      if (out_load) begin
        prev_v    <= vtg;
        acc       <= '0;
        count     <= '0;
        diff_flag <= 1'b1;
        cur_ch    <= (fin_ch == LAST_CELL) ? aocv_pkg::TEMP_CHAN : fin_ch + 3'd1;
        out_word  <= {(fin_ch == 3'd0) ? vtg : vtg - prev_v, fin_ch, 1'b1,
                      (fin_ch == LAST_CELL) ? aocv_pkg::KIND_TEMP : aocv_pkg::KIND_DIFF,
                      (fin_ch == LAST_CELL) ? aocv_pkg::TEMP_CHAN : fin_ch + 3'd1};
        m_tvalid  <= 1'b1;
      end
    end
  end

  assign m_tdata = {7'd0, out_word};

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != aocv_pkg::ST_IDLE |-> !s_tready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid) else $error("result lost");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    state == aocv_pkg::ST_IDLE |-> !mul_start) else $error("stray multiply");

endmodule

// ===== verif/autorange_oversampling_cell_voltage_core_tb.sv =====
`timescale 1ns / 100ps

module autorange_oversampling_cell_voltage_core_tb;

  localparam int NCELL = aocv_pkg::CELL_COUNT_DEF;
  localparam int NSAMP = aocv_pkg::SAMPLES_PER_CELL_DEF;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  index;
    logic        valid;
    logic [1:0]  kind;
    logic [2:0]  chan;
  } meas_t;

  // Model of the monitor plus a queue of predicted result items
  class meas_scoreboard;
    logic [63:0] dgains, sgains;
    logic [15:0] corr, toff;
    logic [2:0]  chan;
    int          count;
    logic [31:0] acc;
    logic        diff;
    logic [15:0] prev;
    meas_t       pending[$];
    int          errors;
    int          cells_done, temps_done;

    function void clear();
      dgains = '0; sgains = '0; corr = 16'hFFFF; toff = '0;
      chan = '0; count = 0; acc = '0; diff = 1'b1; prev = '0;
      errors = 0; cells_done = 0; temps_done = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] d);
      case (idx)
        aocv_pkg::REG_DIFF_GAINS:   dgains = d;
        aocv_pkg::REG_SINGLE_GAINS: sgains = d;
        aocv_pkg::REG_DIFF_CORR:    corr = d[15:0];
        default:                    toff = d[15:0];
      endcase
    endfunction

    function void note_conversion(logic [9:0] code);
      meas_t m;
      logic signed [31:0] smp;
      logic signed [63:0] prod;
      logic [31:0] sum, gain, offs, scaled;
      logic [15:0] vtg;
      m = '0;
      if (chan >= NCELL) begin
        m.value = 16'(code) - toff;
        m.valid = 1'b1; m.index = aocv_pkg::TEMP_CHAN;
        chan = '0; m.chan = '0; m.kind = aocv_pkg::KIND_DIFF;
        temps_done++;
      end else begin
        smp = diff ? 32'(signed'(code)) : 32'(code);
        if (count > 2) acc = acc + smp;
        if (count == 1) diff = !(smp < -480 || smp > 480);
        count++;
        m.chan = chan;
        m.kind = diff ? aocv_pkg::KIND_DIFF : aocv_pkg::KIND_SINGLE;
        if (count >= NSAMP) begin
          sum = acc;
          if (diff) begin
            prod = 64'(signed'(acc)) * $signed({48'd0, corr});
            sum = 32'(prod >>> 16);
            gain = 32'(dgains[16*chan[1:0] +: 16]);
            offs = aocv_pkg::DIFF_OFFSET;
          end else begin
            gain = 32'(sgains[16*chan[1:0] +: 16]);
            offs = '0;
          end
          scaled = (sum + offs) * gain + 32'd65536;
          vtg = {1'b0, scaled[31:17]};
          m.value = (chan == 0) ? vtg : vtg - prev;
          prev = vtg;
          m.valid = 1'b1; m.index = chan;
          acc = '0; count = 0; diff = 1'b1;
          cells_done++;
          if (chan + 1 < NCELL) begin
            chan = chan + 3'd1; m.chan = chan; m.kind = aocv_pkg::KIND_DIFF;
          end else begin
            chan = aocv_pkg::TEMP_CHAN; m.chan = aocv_pkg::TEMP_CHAN;
            m.kind = aocv_pkg::KIND_TEMP;
          end
        end
      end
      pending.push_back(m);
    endfunction

    function void check_result(logic [31:0] d);
      meas_t got, exp_m;
      got = d[24:0];
      if (pending.size() == 0) begin
        $error("result item with nothing predicted: %h", d);
        errors++;
        return;
      end
      exp_m = pending.pop_front();
      if (got.chan !== exp_m.chan) begin
        $error("next_channel exp %0d got %0d", exp_m.chan, got.chan); errors++;
      end
      if (got.kind !== exp_m.kind) begin
        $error("next_kind exp %0d got %0d", exp_m.kind, got.kind); errors++;
      end
      if (got.valid !== exp_m.valid) begin
        $error("result_valid exp %0d got %0d", exp_m.valid, got.valid); errors++;
      end
      if (got.index !== exp_m.index) begin
        $error("result_index exp %0d got %0d", exp_m.index, got.index); errors++;
      end
      if (got.value !== exp_m.value) begin
        $error("measured_value exp %h got %h", exp_m.value, got.value); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  meas_scoreboard sb;
  int cycles;
  int sent;

  autorange_oversampling_cell_voltage_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Check result items; stall the receiver a random number of cycles per item
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] d);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  // Send one conversion; noisy upper bits test that bits above 9 are ignored
  task automatic send_conversion(logic [9:0] code, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'($urandom), code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_conversion(code);
    sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Pick a conversion code: random, small in-range, just beyond the mode threshold or at the extremes
  function automatic logic [9:0] pick_code(int style);
    case (style)
      0: return 10'($urandom);
      1: return 10'($urandom_range(0, 40)) - 10'd20;
      2: return $urandom_range(0, 1) ? 10'd481 + 10'($urandom_range(0, 30))
                                     : 10'd543 - 10'($urandom_range(0, 30));
      default: return $urandom_range(0, 1) ? 10'd511 : 10'd512;
    endcase
  endfunction

  initial begin
    int style, burst;
    sb = new();
    sb.clear();
    sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    cfg_we = 1'b0; cfg_index = aocv_pkg::REG_DIFF_GAINS; cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, threshold values 480/481/-480/-481; only 480 falls on sample 1
    send_conversion(10'd0, 0);
    send_conversion(10'd480, 0);
    send_conversion(10'd1023, 0);
    send_conversion(10'd512, 0);
    send_conversion(10'd511, 1);
    send_conversion(10'd481, 0);
    send_conversion(10'd544, 0);
    send_conversion(10'd543, 0);
    wait_idle();

    write_reg(aocv_pkg::REG_DIFF_GAINS, 64'hFFFF_0001_8000_FFFF);
    write_reg(aocv_pkg::REG_SINGLE_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(aocv_pkg::REG_DIFF_CORR, 64'd0);
    write_reg(aocv_pkg::REG_TEMP_OFFSET, 64'hFFFF);

    // Phases: 290 conversions each over frames of 4 cells plus temperature, with mostly random settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_reg(aocv_pkg::REG_DIFF_GAINS, (ph == 5) ? 64'd0 : {$urandom, $urandom});
        write_reg(aocv_pkg::REG_SINGLE_GAINS, (ph == 5) ? 64'd0 : {$urandom, $urandom});
        write_reg(aocv_pkg::REG_DIFF_CORR, (ph == 4) ? 64'hFFFF : 64'($urandom));
        write_reg(aocv_pkg::REG_TEMP_OFFSET, (ph == 4) ? 64'd0 : 64'($urandom));
      end
      for (int it = 0; it < 290; it++) begin
        if (it % NSAMP == 0) style = $urandom_range(0, 3);
        burst = $urandom_range(0, 4) == 0;
        send_conversion(pick_code(style), burst);
      end
    end

    wait_idle();
    $display("sent %0d conversions: %0d cell results, %0d temperature results",
             sent, sb.cells_done, sb.temps_done);
    $display("covered both modes, threshold codes and several register settings");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aocv_pkg.sv
rtl/aocv_mul.sv
rtl/autorange_oversampling_cell_voltage_core.sv
verif/autorange_oversampling_cell_voltage_core_tb.sv
